// File: hdl/gcwp_pkg.sv
// ----------------------------------------------------------------------------
// gcwp_pkg - shared types and constants of the gpu command word port
// Command opcodes, the queue entry between front and back, the packet size
// lookup and the one-pixel step of the vram rectangle walk.
// ----------------------------------------------------------------------------
package gcwp_pkg;

	// vram geometry
	localparam int unsigned VRAM_ROW_PIXELS = 1024;
	localparam int unsigned VRAM_ROWS       = 512;

	// depth of the command queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;

	// stream widths
	localparam int unsigned S_TDATA_W = 72;
	localparam int unsigned M_TDATA_W = 72;

	// opcodes carried on the input tuser
	typedef enum logic [1:0] {
		OP_DATA  = 2'd0,
		OP_ARM   = 2'd1,
		OP_ABORT = 2'd2
	} op_t;

	// classified command as it sits in the queue
	typedef struct packed {
		op_t         kind;
		logic [31:0] word;
		logic [3:0]  extra;    // extra words of a packet opened by this word
		logic [9:0]  rect_x;
		logic [8:0]  rect_y;
		logic [10:0] x_limit;  // saturated right edge
		logic [9:0]  y_limit;  // saturated bottom edge
	} cmd_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

	// back end state machine
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EMIT_PKT,
		ST_EMIT_PIX
	} back_state_t;

	// outcome of one pixel step of the walk
	typedef struct packed {
		logic        emit;     // pixel lies inside vram
		logic [18:0] addr;
		logic [10:0] x;
		logic [9:0]  y;
		logic        active;   // transfer still armed after the step
	} walk_t;

	// extra-word count of a packet, selected by the command byte
	function automatic logic [3:0] extra_words(input logic [7:0] cmd);
		logic [3:0] n;
		n = 4'd0;
		case (cmd[7:4])
			4'h0: n = (cmd[3:0] == 4'h2) ? 4'd2 : 4'd0;
			4'h2: begin
				case (cmd[3:2])
					2'd0: n = 4'd3;
					2'd1: n = 4'd6;
					2'd2: n = 4'd4;
					default: n = 4'd8;
				endcase
			end
			4'h3: begin
				case (cmd[3:2])
					2'd0: n = 4'd5;
					2'd1: n = 4'd8;
					2'd2: n = 4'd7;
					default: n = 4'd11;
				endcase
			end
			4'h4: begin
				case (cmd[3:2])
					2'd0: n = 4'd2;
					2'd1: n = 4'd0;
					default: n = 4'd3;
				endcase
			end
			4'h5: begin
				case (cmd[3:2])
					2'd0: n = 4'd3;
					2'd1: n = 4'd0;
					default: n = 4'd4;
				endcase
			end
			4'h6: begin
				case (cmd[3:2])
					2'd0: n = 4'd2;
					2'd1: n = 4'd3;
					2'd2: n = 4'd1;
					default: n = 4'd2;
				endcase
			end
			4'h7: n = cmd[2] ? 4'd2 : 4'd1;
			4'h8: n = (cmd[3:0] == 4'h0) ? 4'd3 : 4'd0;
			4'hA: n = (cmd[3:0] == 4'h0) ? 4'd2 : 4'd0;
			4'hC: n = (cmd[3:0] == 4'h0) ? 4'd2 : 4'd0;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

	// one pixel of the rectangle walk: write check, then advance
	function automatic walk_t walk_step(input logic [10:0] x, input logic [9:0] y,
			input logic [10:0] x_begin, input logic [10:0] x_limit,
			input logic [9:0] y_limit);
		walk_t r;
		logic [10:0] nx;
		logic [9:0]  ny;
		r.emit   = (x < 11'(VRAM_ROW_PIXELS)) && (y < 10'(VRAM_ROWS));
		r.addr   = {y[8:0], x[9:0]};
		r.active = 1'b1;
		nx = x + 11'd1;
		ny = y;
		if (nx >= x_limit) begin
			nx = x_begin;
			ny = y + 10'd1;
			if (ny >= y_limit) begin
				r.active = 1'b0;
			end
		end
		r.x = nx;
		r.y = ny;
		return r;
	endfunction

endpackage

// File: hdl/gcwp_front.sv
// ----------------------------------------------------------------------------
// gcwp_front - command classifier
// Takes input beats, looks up the packet size of each data word, saturates
// the rectangle limits of an arm and pushes the result into the queue.
// ----------------------------------------------------------------------------
module gcwp_front (
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// word[31:0], rect_x[41:32], rect_y[50:42], rect_w[61:51], rect_h[71:62]
	input  logic [gcwp_pkg::S_TDATA_W-1:0]      s_tdata,
	// opcode[1:0]
	input  logic [1:0]                          s_tuser,
	input  logic                                full,
	output logic                                push,
	output gcwp_pkg::cmd_t                      push_cmd
);

	logic [31:0] word;
	logic [9:0]  rect_x;
	logic [8:0]  rect_y;
	logic [10:0] rect_w;
	logic [9:0]  rect_h;
	logic [11:0] x_sum;
	logic [10:0] y_sum;
	logic        known_op;

	// unpack the beat
	assign word   = s_tdata[31:0];
	assign rect_x = s_tdata[41:32];
	assign rect_y = s_tdata[50:42];
	assign rect_w = s_tdata[61:51];
	assign rect_h = s_tdata[71:62];

	// rectangle limits, saturated to the walk counter range
	assign x_sum = {2'b00, rect_x} + {1'b0, rect_w};
	assign y_sum = {2'b00, rect_y} + {1'b0, rect_h};

	// undefined opcode is taken and dropped here
	always_comb begin
		case (s_tuser)
			gcwp_pkg::OP_DATA, gcwp_pkg::OP_ARM, gcwp_pkg::OP_ABORT: known_op = 1'b1;
			default: known_op = 1'b0;
		endcase
	end

	assign s_tready = !full;
	assign push     = s_tvalid && !full && known_op;

	// classified command
	always_comb begin
		push_cmd.kind    = gcwp_pkg::op_t'(s_tuser);
		push_cmd.word    = word;
		push_cmd.extra   = gcwp_pkg::extra_words(word[31:24]);
		push_cmd.rect_x  = rect_x;
		push_cmd.rect_y  = rect_y;
		push_cmd.x_limit = x_sum[11] ? 11'h7FF : x_sum[10:0];
		push_cmd.y_limit = y_sum[10] ? 10'h3FF : y_sum[9:0];
	end

endmodule

// File: hdl/gcwp_queue.sv
// ----------------------------------------------------------------------------
// gcwp_queue - command queue
// Small fifo of classified commands that lets the front take beats while the
// back end is still emitting results.
// ----------------------------------------------------------------------------
module gcwp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  gcwp_pkg::cmd_t      push_cmd,
	output logic                full,
	input  logic                pop,
	output gcwp_pkg::q_head_t   head
);

	localparam int unsigned PTR_W = $clog2(gcwp_pkg::QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(gcwp_pkg::QUEUE_DEPTH + 1);

	gcwp_pkg::cmd_t   mem_q [gcwp_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(gcwp_pkg::QUEUE_DEPTH));
	assign do_pop     = pop && (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.cmd   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(gcwp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(gcwp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/gcwp_back.sv
// ----------------------------------------------------------------------------
// gcwp_back - command execution
// Holds the packet store and the rectangle walk, carries out one queued
// command at a time and sends its results through the output register.
// ----------------------------------------------------------------------------
module gcwp_back #(
	parameter int unsigned MAX_PACKET_WORDS = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  gcwp_pkg::q_head_t                  head,
	output logic                               pop,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// packet_word[31:0], word_pos[35:32], vram_address[54:36], pixel[70:55],
	// transfer_active[71]
	output logic [gcwp_pkg::M_TDATA_W-1:0]     m_tdata,
	output logic                               m_tlast,
	// kind[0]
	output logic [0:0]                         m_tuser
);

	localparam int unsigned IDX_W = $clog2(MAX_PACKET_WORDS);
	localparam logic [4:0]  MAX_LEN = 5'(MAX_PACKET_WORDS);

	gcwp_pkg::back_state_t state_q, state_nxt;
	gcwp_pkg::cmd_t        cmd;
	gcwp_pkg::walk_t       step1, step2;

	// packet assembly
	logic [31:0] store_q [MAX_PACKET_WORDS];
	logic [3:0]  words_left_q;
	logic [3:0]  fill_pos_q;
	logic [3:0]  rd_pos_q;
	logic [4:0]  len_q;

	// rectangle walk
	logic        writing_q;
	logic [10:0] cur_x_q;
	logic [9:0]  cur_y_q;
	logic [10:0] x_begin_q;
	logic [10:0] x_limit_q;
	logic [9:0]  y_limit_q;

	// pending pixel writes of one data word
	logic        pv0_q, pv1_q;
	logic [18:0] pa0_q, pa1_q;
	logic [15:0] pp0_q, pp1_q;
	logic        pix_active_q;

	// output register
	logic        out_valid_q;
	logic        out_kind_q;
	logic [31:0] out_word_q;
	logic [3:0]  out_pos_q;
	logic [18:0] out_addr_q;
	logic [15:0] out_pixel_q;
	logic        out_last_q;
	logic        out_active_q;

	logic        take;
	logic        out_free;
	logic        out_load;
	logic [3:0]  wl_nxt;
	logic [3:0]  fp_nxt;
	logic [3:0]  wr_pos;
	logic        wr_en;
	logic        pkt_done;
	logic [4:0]  len_nxt;
	logic        pix_any;
	logic        rd_last;

	assign cmd      = head.cmd;
	assign out_free = !out_valid_q || m_tready;
	assign rd_last  = ({1'b0, rd_pos_q} + 5'd1) == len_q;

	// packet fill bookkeeping for a data word
	always_comb begin
		if (words_left_q != 4'd0) begin
			wl_nxt = words_left_q - 4'd1;
			fp_nxt = fill_pos_q + 4'd1;
			wr_pos = fill_pos_q;
			wr_en  = {1'b0, fill_pos_q} < MAX_LEN;
		end else begin
			wl_nxt = cmd.extra;
			fp_nxt = 4'd1;
			wr_pos = 4'd0;
			wr_en  = 1'b1;
		end
		pkt_done = (wl_nxt == 4'd0);
		len_nxt  = ({1'b0, fp_nxt} > MAX_LEN) ? MAX_LEN : {1'b0, fp_nxt};
	end

	// both pixels of a data word, low half first
	always_comb begin
		step1   = gcwp_pkg::walk_step(cur_x_q, cur_y_q, x_begin_q, x_limit_q, y_limit_q);
		step2   = gcwp_pkg::walk_step(step1.x, step1.y, x_begin_q, x_limit_q, y_limit_q);
		pix_any = step1.emit || (step1.active && step2.emit);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			gcwp_pkg::ST_IDLE: begin
				if (head.valid && cmd.kind == gcwp_pkg::OP_DATA) begin
					if (writing_q) begin
						state_nxt = pix_any ? gcwp_pkg::ST_EMIT_PIX : gcwp_pkg::ST_IDLE;
					end else begin
						state_nxt = pkt_done ? gcwp_pkg::ST_EMIT_PKT : gcwp_pkg::ST_IDLE;
					end
				end
			end
			gcwp_pkg::ST_EMIT_PKT: begin
				if (out_free && rd_last) begin
					state_nxt = gcwp_pkg::ST_IDLE;
				end
			end
			gcwp_pkg::ST_EMIT_PIX: begin
				if (out_free && !(pv0_q && pv1_q)) begin
					state_nxt = gcwp_pkg::ST_IDLE;
				end
			end
			default: state_nxt = gcwp_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		take     = 1'b0;
		out_load = 1'b0;
		case (state_q)
			gcwp_pkg::ST_IDLE:     take     = head.valid;
			gcwp_pkg::ST_EMIT_PKT: out_load = out_free;
			gcwp_pkg::ST_EMIT_PIX: out_load = out_free;
			default: ;
		endcase
	end

	assign pop = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gcwp_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// packet store
	always_ff @(posedge clk) begin
		if (take && cmd.kind == gcwp_pkg::OP_DATA && !writing_q && wr_en) begin
			store_q[wr_pos[IDX_W-1:0]] <= cmd.word;
		end
	end

	// command execution
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_left_q <= '0;
			fill_pos_q   <= '0;
			writing_q    <= 1'b0;
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			x_begin_q    <= '0;
			x_limit_q    <= '0;
			y_limit_q    <= '0;
			rd_pos_q     <= '0;
			len_q        <= '0;
			pv0_q        <= 1'b0;
			pv1_q        <= 1'b0;
			pix_active_q <= 1'b0;
		end else begin
			if (take) begin
				case (cmd.kind)
					gcwp_pkg::OP_ARM: begin
						x_begin_q <= {1'b0, cmd.rect_x};
						cur_x_q   <= {1'b0, cmd.rect_x};
						cur_y_q   <= {1'b0, cmd.rect_y};
						x_limit_q <= cmd.x_limit;
						y_limit_q <= cmd.y_limit;
						writing_q <= 1'b1;
					end
					gcwp_pkg::OP_ABORT: begin
						words_left_q <= '0;
						writing_q    <= 1'b0;
					end
					gcwp_pkg::OP_DATA: begin
						if (writing_q) begin
							cur_x_q      <= step1.active ? step2.x : step1.x;
							cur_y_q      <= step1.active ? step2.y : step1.y;
							writing_q    <= step1.active && step2.active;
							pix_active_q <= step1.active && step2.active;
							pv0_q        <= step1.emit;
							pv1_q        <= step1.active && step2.emit;
						end else begin
							words_left_q <= wl_nxt;
							fill_pos_q   <= fp_nxt;
							rd_pos_q     <= '0;
							len_q        <= len_nxt;
						end
					end
					default: ;
				endcase
			end
			// retire the result just loaded
			if (out_load) begin
				if (state_q == gcwp_pkg::ST_EMIT_PKT) begin
					rd_pos_q <= rd_pos_q + 4'd1;
				end else if (pv0_q) begin
					pv0_q <= 1'b0;
				end else begin
					pv1_q <= 1'b0;
				end
			end
		end
	end

	// pixel payload of the pending writes
	always_ff @(posedge clk) begin
		if (take && cmd.kind == gcwp_pkg::OP_DATA && writing_q) begin
			pa0_q <= step1.addr;
			pa1_q <= step2.addr;
			pp0_q <= cmd.word[15:0];
			pp1_q <= cmd.word[31:16];
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (state_q == gcwp_pkg::ST_EMIT_PKT) begin
				out_kind_q   <= 1'b0;
				out_word_q   <= store_q[rd_pos_q[IDX_W-1:0]];
				out_pos_q    <= rd_pos_q;
				out_addr_q   <= '0;
				out_pixel_q  <= '0;
				out_last_q   <= rd_last;
				out_active_q <= writing_q;
			end else begin
				out_kind_q   <= 1'b1;
				out_word_q   <= '0;
				out_pos_q    <= '0;
				out_addr_q   <= pv0_q ? pa0_q : pa1_q;
				out_pixel_q  <= pv0_q ? pp0_q : pp1_q;
				out_last_q   <= !(pv0_q && pv1_q);
				out_active_q <= pix_active_q;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_active_q, out_pixel_q, out_addr_q, out_pos_q, out_word_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_kind_q;

	// pixel emission only runs with a write pending
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gcwp_pkg::ST_EMIT_PIX |-> (pv0_q || pv1_q))
		else $error("pixel emission with no pending write");

	// packet read stays inside the assembled packet
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gcwp_pkg::ST_EMIT_PKT |-> ({1'b0, rd_pos_q} < len_q))
		else $error("packet read beyond packet length");

	// packet words never come out while a transfer is armed
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && state_q == gcwp_pkg::ST_EMIT_PKT) |=> !out_active_q)
		else $error("packet word flagged with transfer active");

	// no command taken while results of the last one are still going out
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != gcwp_pkg::ST_IDLE) |-> !pop)
		else $error("command popped during emission");

endmodule

// File: hdl/gpu_command_word_port_unit.sv
// ----------------------------------------------------------------------------
// gpu_command_word_port_unit - gpu command port packet assembler
// Collects command packets from a 32-bit word stream and emits them word by
// word, or turns data words into vram pixel writes while a transfer is armed.
// ----------------------------------------------------------------------------
// The input side takes one beat per cycle as long as the four-entry command
// queue has room; arm, abort and undefined opcodes never produce results. The
// back end executes one queued command at a time and takes no new command
// while results of the last one are still going out: a word that closes a
// packet sends the packet word by word (up to MAX_PACKET_WORDS words) from
// the packet store through the output register, and a pixel word sends one
// result per pixel written (zero to two). A stalled master side holds results
// in the output register while input beats keep filling the queue.
module gpu_command_word_port_unit #(
	parameter int unsigned MAX_PACKET_WORDS = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// word[31:0], rect_x[41:32], rect_y[50:42], rect_w[61:51], rect_h[71:62]
	input  logic [gcwp_pkg::S_TDATA_W-1:0]     s_tdata,
	// opcode[1:0]
	input  logic [1:0]                         s_tuser,
	input  logic                               s_tlast,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// packet_word[31:0], word_pos[35:32], vram_address[54:36], pixel[70:55],
	// transfer_active[71]
	output logic [gcwp_pkg::M_TDATA_W-1:0]     m_tdata,
	output logic                               m_tlast,
	// kind[0]
	output logic [0:0]                         m_tuser
);

	logic              full;
	logic              push;
	logic              pop;
	gcwp_pkg::cmd_t    push_cmd;
	gcwp_pkg::q_head_t head;

	// classify incoming beats (end-of-burst marks carry no meaning here)
	gcwp_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// command queue
	gcwp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.head     (head)
	);

	// execution and result output
	gcwp_back #(
		.MAX_PACKET_WORDS (MAX_PACKET_WORDS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule
